>>> rtl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg: shared definitions for the vector normalize core.
// Holds the component count used by every stage of the pipeline.
// ----------------------------------------------------------------------------
package vn_pkg;

  // Number of vector components handled side by side.
  localparam int NUM_COMP = 3;

  // Index of one component lane.
  typedef logic [1:0] comp_idx_t;

  // Lane numbers of the three components.
  localparam comp_idx_t COMP_X = 2'd0;
  localparam comp_idx_t COMP_Y = 2'd1;
  localparam comp_idx_t COMP_Z = 2'd2;

endpackage

>>> rtl/vn_square.sv
// ----------------------------------------------------------------------------
// vn_square: magnitude, square and sum of squares.
// Three register stages: absolute values, squares, then their sum.
// ----------------------------------------------------------------------------
module vn_square #(
  parameter int W = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [W-1:0]         comp_i [vn_pkg::NUM_COMP],
  output logic                        valid_o,
  output logic [2*W-1:0]              sum_o,
  output logic [W-1:0]                mag_o  [vn_pkg::NUM_COMP],
  output logic [vn_pkg::NUM_COMP-1:0] neg_o
);
  import vn_pkg::*;

  logic                valid_a_q, valid_b_q, valid_c_q;
  logic [W-1:0]        mag_a_q [NUM_COMP];
  logic [W-1:0]        mag_b_q [NUM_COMP];
  logic [W-1:0]        mag_c_q [NUM_COMP];
  logic [NUM_COMP-1:0] neg_a_q, neg_b_q, neg_c_q;
  logic [2*W-1:0]      sq_b_q  [NUM_COMP];
  logic [2*W-1:0]      sum_c_q;

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  // Split each component into sign and magnitude, square it, and sum the squares.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_COMP; c++) begin
      neg_a_q[c] <= comp_i[c][W-1];
      mag_a_q[c] <= comp_i[c][W-1] ? (~$unsigned(comp_i[c]) + W'(1)) : $unsigned(comp_i[c]);
      sq_b_q[c]  <= (2*W)'(mag_a_q[c]) * (2*W)'(mag_a_q[c]);
      mag_b_q[c] <= mag_a_q[c];
      mag_c_q[c] <= mag_b_q[c];
    end
    neg_b_q <= neg_a_q;
    neg_c_q <= neg_b_q;
    sum_c_q <= sq_b_q[COMP_X] + sq_b_q[COMP_Y] + sq_b_q[COMP_Z];
  end

  assign valid_o = valid_c_q;
  assign sum_o   = sum_c_q;
  assign mag_o   = mag_c_q;
  assign neg_o   = neg_c_q;

endmodule

>>> rtl/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined floor square root.
// One root bit per register stage, most significant bit first.
// ----------------------------------------------------------------------------
module vn_sqrt #(
  parameter int W = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [2*W-1:0]              sum_i,
  input  logic [W-1:0]                mag_i [vn_pkg::NUM_COMP],
  input  logic [vn_pkg::NUM_COMP-1:0] neg_i,
  output logic                        valid_o,
  output logic [W-1:0]                root_o,
  output logic [W-1:0]                mag_o [vn_pkg::NUM_COMP],
  output logic [vn_pkg::NUM_COMP-1:0] neg_o
);
  import vn_pkg::*;

  localparam int TW = 2 * W + 1;

  logic                valid_q [W];
  logic [2*W-1:0]      rem_q   [W];
  logic [W-1:0]        root_q  [W];
  logic [W-1:0]        mag_q   [W][NUM_COMP];
  logic [NUM_COMP-1:0] neg_q   [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int K = W - 1 - s;

    logic                valid_in;
    logic [2*W-1:0]      rem_in;
    logic [W-1:0]        root_in;
    logic [W-1:0]        mag_in [NUM_COMP];
    logic [NUM_COMP-1:0] neg_in;
    logic [TW-1:0]       trial;
    logic                fits;

    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = sum_i;
      assign root_in  = '0;
      assign mag_in   = mag_i;
      assign neg_in   = neg_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign root_in  = root_q[s-1];
      assign mag_in   = mag_q[s-1];
      assign neg_in   = neg_q[s-1];
    end

    // Setting bit K adds 2*root*2^K + 2^2K to the square.
    assign trial = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
    assign fits  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= fits ? (rem_in - trial[2*W-1:0]) : rem_in;
      root_q[s] <= fits ? (root_in | (W'(1) << K)) : root_in;
      mag_q[s]  <= mag_in;
      neg_q[s]  <= neg_in;
    end
  end

  assign valid_o = valid_q[W-1];
  assign root_o  = root_q[W-1];
  assign mag_o   = mag_q[W-1];
  assign neg_o   = neg_q[W-1];

endmodule

>>> rtl/vn_div.sv
// ----------------------------------------------------------------------------
// vn_div: pipelined restoring divide of each magnitude by the length.
// One quotient bit per stage for all three lanes, then the signed result.
// ----------------------------------------------------------------------------
module vn_div #(
  parameter int W = 16,
  parameter int F = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [W-1:0]                len_i,
  input  logic [W-1:0]                mag_i  [vn_pkg::NUM_COMP],
  input  logic [vn_pkg::NUM_COMP-1:0] neg_i,
  output logic                        valid_o,
  output logic signed [F+1:0]         unit_o [vn_pkg::NUM_COMP],
  output logic [W-1:0]                len_o,
  output logic                        zero_o
);
  import vn_pkg::*;

  localparam int NS = F + 1;

  logic                valid_q [NS];
  logic [W-1:0]        len_q   [NS];
  logic [NUM_COMP-1:0] neg_q   [NS];
  logic [W-1:0]        rem_q   [NS][NUM_COMP];
  logic [F:0]          quot_q  [NS][NUM_COMP];

  logic                valid_out_q;
  logic signed [F+1:0] unit_out_q [NUM_COMP];
  logic [W-1:0]        len_out_q;
  logic                zero_out_q;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = F - s;

    logic                valid_in;
    logic [W-1:0]        len_in;
    logic [NUM_COMP-1:0] neg_in;
    logic [W:0]          shifted [NUM_COMP];
    logic [F:0]          quot_in [NUM_COMP];
    logic [NUM_COMP-1:0] bit_set;

    // The first stage makes the integer bit; later stages shift the remainder.
    if (s == 0) begin : g_first
      assign valid_in = valid_i;
      assign len_in   = len_i;
      assign neg_in   = neg_i;
      for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
        assign shifted[c] = {1'b0, mag_i[c]};
        assign quot_in[c] = '0;
      end
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign len_in   = len_q[s-1];
      assign neg_in   = neg_q[s-1];
      for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
        assign shifted[c] = {rem_q[s-1][c], 1'b0};
        assign quot_in[c] = quot_q[s-1][c];
      end
    end

    for (genvar c = 0; c < NUM_COMP; c++) begin : g_cmp
      assign bit_set[c] = shifted[c] >= {1'b0, len_in};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      len_q[s] <= len_in;
      neg_q[s] <= neg_in;
      for (int c = 0; c < NUM_COMP; c++) begin
        rem_q[s][c]  <= bit_set[c] ? W'(shifted[c] - {1'b0, len_in}) : W'(shifted[c]);
        quot_q[s][c] <= quot_in[c] | ((F+1)'(bit_set[c]) << B);
      end
    end
  end

  // Output word: apply signs, force zeros for a zero-length vector.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
    end else begin
      valid_out_q <= valid_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    zero_out_q <= (len_q[NS-1] == '0);
    len_out_q  <= len_q[NS-1];
    for (int c = 0; c < NUM_COMP; c++) begin
      if (len_q[NS-1] == '0) begin
        unit_out_q[c] <= '0;
      end else if (neg_q[NS-1][c]) begin
        unit_out_q[c] <= -$signed({1'b0, quot_q[NS-1][c]});
      end else begin
        unit_out_q[c] <= $signed({1'b0, quot_q[NS-1][c]});
      end
    end
  end

  assign valid_o = valid_out_q;
  assign unit_o  = unit_out_q;
  assign len_o   = len_out_q;
  assign zero_o  = zero_out_q;

endmodule

>>> rtl/vector3_normalize_core.sv
// ----------------------------------------------------------------------------
// vector3_normalize_core: normalizes a 3-component signed Q8.8 vector.
// Gives each component over the floor square-root length in signed Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   Drive comp_x_i, comp_y_i and comp_z_i and raise start_i for one cycle per
//   input word. A word is taken at every rising edge with start_i high and
//   busy_o low; busy_o is always low, so a new word may enter every cycle.
//   Each result word appears on unit_x_o, unit_y_o, unit_z_o, vec_length_o
//   and zero_length_o for exactly one cycle, marked by done_o.
//   Each word passes in order through registers for magnitudes, squares and
//   their sum, the square root pipeline, which makes the root bits, the
//   divide pipeline, which makes the quotient bits, and the output register.
//   Throughput is one word per cycle.
//   A zero vector gives zero components, zero length and zero_length_o high.
//   Reset clears every valid bit at once; words in flight are dropped.
//   Results are shown once and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module vector3_normalize_core #(
  parameter int COMPONENT_WIDTH  = 16,
  parameter int OUTPUT_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [COMPONENT_WIDTH-1:0] comp_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] comp_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] comp_z_i,
  output logic                              done_o,
  output logic signed [OUTPUT_FRAC_BITS+1:0] unit_x_o,
  output logic signed [OUTPUT_FRAC_BITS+1:0] unit_y_o,
  output logic signed [OUTPUT_FRAC_BITS+1:0] unit_z_o,
  output logic [COMPONENT_WIDTH-1:0]        vec_length_o,
  output logic                              zero_length_o
);
  import vn_pkg::*;

  localparam int W        = COMPONENT_WIDTH;
  localparam int F        = OUTPUT_FRAC_BITS;
  localparam int LATENCY  = W + F + 5;
  localparam int UNIT_ONE = 1 << F;

  logic signed [W-1:0] comp_in [NUM_COMP];

  logic                sq_valid;
  logic [2*W-1:0]      sq_sum;
  logic [W-1:0]        sq_mag [NUM_COMP];
  logic [NUM_COMP-1:0] sq_neg;

  logic                rt_valid;
  logic [W-1:0]        rt_root;
  logic [W-1:0]        rt_mag [NUM_COMP];
  logic [NUM_COMP-1:0] rt_neg;

  logic signed [F+1:0] unit_out [NUM_COMP];

  // The pipeline never stalls, so a word is taken every cycle.
  assign busy_o = 1'b0;

  assign comp_in[COMP_X] = comp_x_i;
  assign comp_in[COMP_Y] = comp_y_i;
  assign comp_in[COMP_Z] = comp_z_i;

  // Sum of squares.
  vn_square #(.W(W)) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .comp_i  (comp_in),
    .valid_o (sq_valid),
    .sum_o   (sq_sum),
    .mag_o   (sq_mag),
    .neg_o   (sq_neg)
  );

  // Length as floor square root.
  vn_sqrt #(.W(W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .sum_i   (sq_sum),
    .mag_i   (sq_mag),
    .neg_i   (sq_neg),
    .valid_o (rt_valid),
    .root_o  (rt_root),
    .mag_o   (rt_mag),
    .neg_o   (rt_neg)
  );

  // Component over length.
  vn_div #(.W(W), .F(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rt_valid),
    .len_i   (rt_root),
    .mag_i   (rt_mag),
    .neg_i   (rt_neg),
    .valid_o (done_o),
    .unit_o  (unit_out),
    .len_o   (vec_length_o),
    .zero_o  (zero_length_o)
  );

  assign unit_x_o = unit_out[COMP_X];
  assign unit_y_o = unit_out[COMP_Y];
  assign unit_z_o = unit_out[COMP_Z];

  // A result word only follows an accepted input word at the fixed latency.
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result word without a matching input word");

  // A zero-length result carries all-zero fields.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && zero_length_o) |-> (unit_x_o == '0 && unit_y_o == '0 &&
                                   unit_z_o == '0 && vec_length_o == '0))
    else $error("zero-length result with nonzero fields");

  // The zero flag agrees with the length.
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (zero_length_o == (vec_length_o == '0)))
    else $error("zero flag disagrees with length");

  // Unit components stay within plus or minus one.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (int'(unit_x_o) <= UNIT_ONE && int'(unit_x_o) >= -UNIT_ONE &&
                int'(unit_y_o) <= UNIT_ONE && int'(unit_y_o) >= -UNIT_ONE &&
                int'(unit_z_o) <= UNIT_ONE && int'(unit_z_o) >= -UNIT_ONE))
    else $error("unit component out of range");

endmodule
